// File: rtl/s2da_pkg.sv
// shared types and constants for the signed to decimal ascii converter
// no dependencies
package s2da_pkg;

    localparam int VALUE_W    = 16;
    localparam int NUM_DIGITS = 5;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = $clog2(VALUE_W + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic step_bit;
        logic step_digit;
    } cell_ctrl_t;

endpackage

// File: rtl/signed_to_decimal_ascii.sv
// signed 16-bit to decimal ascii text: sign, then digits most significant first
// one conversion step per magnitude bit, a minus sign beat for a negative value, then
// one step per digit (leading zeros are dropped but still shifted out); each beat is
// registered; busy stays high until idle again, and only then is a new value taken;
// the shift-and-add-3 cell chain steps once per magnitude bit and once per digit out
// reset is asynchronous active low and returns the controller to idle
module signed_to_decimal_ascii (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [s2da_pkg::VALUE_W-1:0] value,
    output logic                                busy,
    output logic                                strobe,
    output logic [s2da_pkg::CHAR_W-1:0]         char_code,
    output logic                                last_char
);
    import s2da_pkg::*;

    state_t                state_reg, state_next;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  started_reg, started_next;
    logic                  strobe_reg, strobe_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;

    cell_ctrl_t            ctrl;
    logic [VALUE_W-1:0]    raw;
    logic [VALUE_W-1:0]    in_mag;
    logic [NUM_DIGITS:0]   carry;
    logic [3:0]            digits [NUM_DIGITS];
    logic [3:0]            top;

    // -32768 wraps to 0x8000, which is exactly its magnitude
    assign raw    = value;
    assign in_mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

    assign carry[0] = mag_reg[VALUE_W-1];
    assign top      = digits[NUM_DIGITS-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            logic [3:0] din;
            if (g == 0)
            begin : g_first
                assign din = 4'd0;
            end
            else
            begin : g_rest
                assign din = digits[g-1];
            end
            s2da_bcd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (carry[g]),
                .digit_in  (din),
                .carry_out (carry[g+1]),
                .digit     (digits[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        ctrl         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.clear   = 1'b1;
                    mag_next     = in_mag;
                    neg_next     = raw[VALUE_W-1];
                    cnt_next     = CNT_W'(VALUE_W);
                    started_next = 1'b0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.step_bit = 1'b1;
                mag_next      = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next      = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(NUM_DIGITS);
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                ctrl.step_digit = 1'b1;
                cnt_next        = cnt_reg - CNT_W'(1);
                // leading zeros shift out silently; the units digit always goes out
                if (top != 4'd0 || started_reg || cnt_reg == CNT_W'(1))
                begin
                    strobe_next  = 1'b1;
                    char_next    = CHAR_ZERO + CHAR_W'(top);
                    last_next    = (cnt_reg == CNT_W'(1));
                    started_next = 1'b1;
                end
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

// File: rtl/s2da_bcd_cell.sv
// one bcd digit cell of the shift-and-add-3 chain
// depends on s2da_pkg
module s2da_bcd_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  s2da_pkg::cell_ctrl_t ctrl,
    input  logic              carry_in,
    input  logic [3:0]        digit_in,
    output logic              carry_out,
    output logic [3:0]        digit
);
    import s2da_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 before the shift so the doubled digit carries at ten
    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.step_bit)
        begin
            digit_next = {adj[2:0], carry_in};
        end
        else if (ctrl.step_digit)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// File: rtl/s2da_checker.sv
// port-level checks for signed_to_decimal_ascii, bound to the top level
// depends on s2da_pkg and the top level's ports
module s2da_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [s2da_pkg::VALUE_W-1:0] value,
    input  logic                                busy,
    input  logic                                strobe,
    input  logic [s2da_pkg::CHAR_W-1:0]         char_code,
    input  logic                                last_char
);
    import s2da_pkg::*;

    // every beat is a minus sign or a decimal digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == CHAR_MINUS ||
                    (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + CHAR_W'(9))))
        else $error("char_code out of range");

    // a minus sign never ends the text
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && char_code == CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last");

    // a text that is not finished keeps the block busy
    a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_char) |-> busy)
        else $error("idle in the middle of a text");

    // conversion of a new value shows no beat in the next cycle
    a_quiet_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && $stable(value)) |=> (busy && !strobe))
        else $error("beat or idle right after accept");

endmodule

bind signed_to_decimal_ascii s2da_checker u_s2da_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
);
